>>> sv/lcis_pkg.sv
// ----------------------------------------------------------------------------
// lcis_pkg: shared types and constants for the Langevin charge integrator
// Mode codes, configuration register indexes, multiplier operand selects and
// the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lcis_pkg;

  localparam int MODE_W    = 2;
  localparam int ITER_W    = 4;
  localparam int CFG_IDX_W = 3;

  // Multiplier digit width: bits of the second operand consumed per cycle
  localparam int MUL_DIGIT = 8;

  // Reset values that do not follow from the word format
  localparam int TOL_RESET = 4295;
  localparam logic [ITER_W-1:0] ITER_RESET = 4'd4;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_KICK_DRIFT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FRICTION   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FINAL_KICK = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAG       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 3'd4;

  // Multiplier coefficient selects
  localparam logic [1:0] OPA_HALF = 2'd0;
  localparam logic [1:0] OPA_STEP = 2'd1;
  localparam logic [1:0] OPA_DRAG = 2'd2;

  typedef struct packed {
    logic       load;        // capture the input item
    logic       f_add_r;     // force += random force (also into kick operand)
    logic       mul_start;
    logic [1:0] mul_a_sel;   // OPA_* coefficient
    logic       mul_b_est;   // 1: estimate register, 0: kick operand
    logic       div_start;
    logic       est_load;    // estimate = velocity + quotient
    logic       p_load;      // position += product
    logic       round_start; // old friction = friction
    logic       ff_load;     // friction = -product
    logic       x_fsum;      // kick operand = force + friction
    logic       fin;         // load the output register
    logic       fin_use_est; // velocity result comes from the estimate
    logic       fin_conv;
  } lcis_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic tol_hit;  // friction change within tolerance
  } lcis_sts_t;

endpackage

>>> sv/langevin_charge_integrator_step.sv
// ----------------------------------------------------------------------------
// langevin_charge_integrator_step: Langevin velocity-Verlet charge update
// One fluctuating-charge item in, one updated item out, signed fixed point
// with saturation throughout.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready item channel (mode, velocity, position, force, mass,
//           random force); a transfer happens when in_valid and in_ready are high.
//   out_* : valid/ready result channel, one result per input item.
//   cfg_* : write-only register port, cfg_wr_en writes cfg_data to cfg_index;
//           write only while no item is in flight.
// Timing: one item at a time. The length of a kick (multiply by half step,
//   divide by mass) is set by the bit-serial divider that makes one quotient
//   bit per cycle. Mode 1 adds a drag multiply and a kick per friction round;
//   a disabled item or mode 3 skips the datapath and goes to the output.
// The output register decouples the sides: a new item is accepted while the
//   previous result waits; a finished item holds until out_ready frees it.
// Reset (rst_n low, synchronous) restores register defaults (enable 1, step
//   1.0, drag 0, tolerance 4295, limit 4) and drops out_valid.
// ----------------------------------------------------------------------------
module langevin_charge_integrator_step import lcis_pkg::*; #(
  parameter int WORD_BITS     = 48,
  parameter int FRACTION_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // item input
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [MODE_W-1:0]           in_mode,
  input  logic signed [WORD_BITS-1:0] in_charge_velocity,
  input  logic signed [WORD_BITS-1:0] in_charge_position,
  input  logic signed [WORD_BITS-1:0] in_charge_force,
  input  logic [WORD_BITS-2:0]        in_charge_mass,
  input  logic signed [WORD_BITS-1:0] in_random_force,
  // result output
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [WORD_BITS-1:0] out_new_velocity,
  output logic signed [WORD_BITS-1:0] out_new_position,
  output logic signed [WORD_BITS-1:0] out_new_force,
  output logic                        out_converged,
  // configuration writes
  input  logic                        cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [WORD_BITS-2:0]        cfg_data
);

  localparam int W = WORD_BITS;
  localparam int F = FRACTION_BITS;
  // 1.0 in the unsigned step format
  localparam logic [W-2:0] TS_ONE   = {{(W-2){1'b0}}, 1'b1};
  localparam logic [W-2:0] TS_RESET = TS_ONE << F;

  // Configuration registers
  logic              enable_r;
  logic [W-2:0]      time_step_r;
  logic [W-2:0]      drag_r;
  logic [W-2:0]      tol_r;
  logic [ITER_W-1:0] iter_limit_r;

  lcis_cmd_t cmd;
  lcis_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b1;
      time_step_r  <= TS_RESET;
      drag_r       <= '0;
      tol_r        <= (W-1)'(TOL_RESET);
      iter_limit_r <= ITER_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ENABLE:     enable_r     <= cfg_data[0];
        CFG_TIME_STEP:  time_step_r  <= cfg_data;
        CFG_DRAG:       drag_r       <= cfg_data;
        CFG_TOLERANCE:  tol_r        <= cfg_data;
        CFG_ITER_LIMIT: iter_limit_r <= cfg_data[ITER_W-1:0];
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // Sequencer: one state per datapath step, waits on unit done pulses
  lcis_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cfg_enable     (enable_r),
    .cfg_iter_limit (iter_limit_r),
    .sts            (sts),
    .cmd            (cmd)
  );

  // Datapath: item registers, shared multiplier/divider, output register
  lcis_dp #(.W(W), .F(F)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_time_step      (time_step_r),
    .cfg_drag           (drag_r),
    .cfg_tol            (tol_r),
    .in_charge_velocity (in_charge_velocity),
    .in_charge_position (in_charge_position),
    .in_charge_force    (in_charge_force),
    .in_charge_mass     (in_charge_mass),
    .in_random_force    (in_random_force),
    .out_new_velocity   (out_new_velocity),
    .out_new_position   (out_new_position),
    .out_new_force      (out_new_force),
    .out_converged      (out_converged)
  );

`ifndef ASSERT_OFF
  // One item at a time: after an input transfer the block is busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // Convergence can only be reported by an enabled friction pass
  a_conv_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_converged) |-> enable_r)
    else $error("converged flag with block disabled");

  // Multiplier and divider run strictly one after the other
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(sts.mul_done && sts.div_done))
    else $error("multiplier and divider finished together");
`endif

endmodule

>>> sv/lcis_mul.sv
// ----------------------------------------------------------------------------
// lcis_mul: digit-serial fixed-point multiplier
// Nonnegative coefficient times signed operand, one digit per cycle, MSB
// digit first; the product is shifted down by F and saturated.
// ----------------------------------------------------------------------------
module lcis_mul import lcis_pkg::*; #(
  parameter int W = 48,
  parameter int F = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [W-2:0]        a_mag,
  input  logic signed [W-1:0] b,
  output logic                done,
  output logic signed [W-1:0] res
);

  localparam int MSTEPS = (W + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int BPAD   = MSTEPS * MUL_DIGIT;
  localparam int PW     = (2 * W > W + F) ? 2 * W : W + F;
  localparam int SW     = PW - F;
  localparam int CW     = $clog2(MSTEPS + 1);
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  logic                    busy_r, sat_r, done_r;
  logic [CW-1:0]           cnt_r;
  logic [W-2:0]            a_r;
  logic [BPAD-1:0]         bsh_r;
  logic [PW-1:0]           acc_r, acc_nxt;
  logic                    neg_r;
  logic [W-1:0]            res_r, res_nxt;
  logic [W-1:0]            b_u, b_mag;
  logic [W+MUL_DIGIT-2:0]  part;
  logic [SW-1:0]           shv;
  logic                    ovf;
  logic [W-1:0]            mag;

  assign b_u   = b;
  assign b_mag = b_u[W-1] ? (~b_u + {{(W-1){1'b0}}, 1'b1}) : b_u;

  assign part    = a_r * bsh_r[BPAD-1 -: MUL_DIGIT];
  assign acc_nxt = {acc_r[PW-MUL_DIGIT-1:0], {MUL_DIGIT{1'b0}}} + PW'(part);

  assign shv = acc_r[PW-1:F];
  assign ovf = |shv[SW-1:W-1];
  assign mag = shv[W-1:0];

  always_comb begin
    if (neg_r) begin
      res_nxt = ovf ? WMIN : (~mag + {{(W-1){1'b0}}, 1'b1});
    end else begin
      res_nxt = ovf ? WMAX : mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      sat_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= sat_r;
      sat_r  <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        sat_r  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a_mag;
      bsh_r <= BPAD'(b_mag);
      acc_r <= '0;
      neg_r <= b_u[W-1];
      cnt_r <= CW'(MSTEPS);
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      bsh_r <= {bsh_r[BPAD-MUL_DIGIT-1:0], {MUL_DIGIT{1'b0}}};
      cnt_r <= cnt_r - CW'(1);
    end
    if (sat_r) begin
      res_r <= res_nxt;
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

>>> sv/lcis_div.sv
// ----------------------------------------------------------------------------
// lcis_div: bit-serial fixed-point divider
// Restoring division of (|a| << F) by an unsigned divisor, one quotient bit
// per cycle, then sign and saturation. x/0 saturates by sign, 0/0 is 0.
// ----------------------------------------------------------------------------
module lcis_div import lcis_pkg::*; #(
  parameter int W = 48,
  parameter int F = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [W-1:0] a,
  input  logic [W-2:0]        m,
  output logic                done,
  output logic signed [W-1:0] res
);

  localparam int N  = W + F;
  localparam int CW = $clog2(N + 1);
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  logic           busy_r, sat_r, done_r;
  logic [CW-1:0]  cnt_r;
  logic [N-1:0]   num_r;
  logic [W-2:0]   rem_r, rem_nxt;
  logic [W-2:0]   m_r;
  logic           neg_r, az_r;
  logic [W-1:0]   res_r, res_nxt;
  logic [W-1:0]   a_u, a_mag;
  logic [W-1:0]   rem_sh, rem_diff;
  logic           ge;
  logic           ovf;
  logic [W-1:0]   mag;

  assign a_u   = a;
  assign a_mag = a_u[W-1] ? (~a_u + {{(W-1){1'b0}}, 1'b1}) : a_u;

  assign rem_sh   = {rem_r, num_r[N-1]};
  assign ge       = rem_sh >= {1'b0, m_r};
  assign rem_diff = rem_sh - {1'b0, m_r};
  assign rem_nxt  = ge ? rem_diff[W-2:0] : rem_sh[W-2:0];

  assign ovf = |num_r[N-1:W-1];
  assign mag = num_r[W-1:0];

  always_comb begin
    if (az_r) begin
      res_nxt = '0;
    end else if (neg_r) begin
      res_nxt = ovf ? WMIN : (~mag + {{(W-1){1'b0}}, 1'b1});
    end else begin
      res_nxt = ovf ? WMAX : mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      sat_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= sat_r;
      sat_r  <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        sat_r  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= {a_mag, {F{1'b0}}};
      rem_r <= '0;
      m_r   <= m;
      neg_r <= a_u[W-1];
      az_r  <= (a_u == '0);
      cnt_r <= CW'(N);
    end else if (busy_r) begin
      num_r <= {num_r[N-2:0], ge};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - CW'(1);
    end
    if (sat_r) begin
      res_r <= res_nxt;
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

>>> sv/lcis_dp.sv
// ----------------------------------------------------------------------------
// lcis_dp: integrator datapath
// Item registers, saturating adders, shared multiplier and divider, the
// friction convergence test and the output register.
// ----------------------------------------------------------------------------
module lcis_dp import lcis_pkg::*; #(
  parameter int W = 48,
  parameter int F = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lcis_cmd_t           cmd,
  output lcis_sts_t           sts,
  input  logic [W-2:0]        cfg_time_step,
  input  logic [W-2:0]        cfg_drag,
  input  logic [W-2:0]        cfg_tol,
  input  logic signed [W-1:0] in_charge_velocity,
  input  logic signed [W-1:0] in_charge_position,
  input  logic signed [W-1:0] in_charge_force,
  input  logic [W-2:0]        in_charge_mass,
  input  logic signed [W-1:0] in_random_force,
  output logic signed [W-1:0] out_new_velocity,
  output logic signed [W-1:0] out_new_position,
  output logic signed [W-1:0] out_new_force,
  output logic                out_converged
);

  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  function automatic logic [W-1:0] add_sat(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) begin
      add_sat = s[W] ? WMIN : WMAX;
    end else begin
      add_sat = s[W-1:0];
    end
  endfunction

  logic [W-1:0] v_r, p_r, f_r, x_r, est_r, ff_r, old_r, r_r;
  logic [W-2:0] m_r;
  logic [W-1:0] ov_r, op_r, of_r;
  logic         oc_r;

  logic [W-2:0] mul_a;
  logic [W-1:0] mul_b;
  logic         mul_done, div_done;
  logic signed [W-1:0] mul_res, div_res;
  logic [W-1:0] prod_u, quot_u, prod_neg;
  logic [W-1:0] f_plus_r, v_plus_q, p_plus_prod, f_plus_ff;
  logic [W:0]   ff_diff, ff_dmag;

  always_comb begin
    unique case (cmd.mul_a_sel)
      OPA_HALF: mul_a = {1'b0, cfg_time_step[W-2:1]};
      OPA_STEP: mul_a = cfg_time_step;
      OPA_DRAG: mul_a = cfg_drag;
      default:  mul_a = '0;
    endcase
  end

  assign mul_b = cmd.mul_b_est ? est_r : x_r;

  lcis_mul #(.W(W), .F(F)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a_mag (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  lcis_div #(.W(W), .F(F)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .a     (mul_res),
    .m     (m_r),
    .done  (div_done),
    .res   (div_res)
  );

  assign prod_u = mul_res;
  assign quot_u = div_res;
  // friction is minus the product; the most negative value maps to the max
  assign prod_neg = (prod_u == WMIN) ? WMAX : (~prod_u + {{(W-1){1'b0}}, 1'b1});

  assign f_plus_r    = add_sat(f_r, r_r);
  assign v_plus_q    = add_sat(v_r, quot_u);
  assign p_plus_prod = add_sat(p_r, prod_u);
  assign f_plus_ff   = add_sat(f_r, ff_r);

  // |friction - previous friction| against tolerance
  assign ff_diff = {ff_r[W-1], ff_r} - {old_r[W-1], old_r};
  assign ff_dmag = ff_diff[W] ? (~ff_diff + {{W{1'b0}}, 1'b1}) : ff_diff;

  assign sts.mul_done = mul_done;
  assign sts.div_done = div_done;
  assign sts.tol_hit  = ff_dmag <= {2'b00, cfg_tol};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v_r   <= in_charge_velocity;
      p_r   <= in_charge_position;
      f_r   <= in_charge_force;
      x_r   <= in_charge_force;
      m_r   <= in_charge_mass;
      r_r   <= in_random_force;
      ff_r  <= '0;
      old_r <= '0;
    end
    if (cmd.f_add_r) begin
      f_r <= f_plus_r;
      x_r <= f_plus_r;
    end
    if (cmd.x_fsum) begin
      x_r <= f_plus_ff;
    end
    if (cmd.est_load) begin
      est_r <= v_plus_q;
    end
    if (cmd.p_load) begin
      p_r <= p_plus_prod;
    end
    if (cmd.round_start) begin
      old_r <= ff_r;
    end
    if (cmd.ff_load) begin
      ff_r <= prod_neg;
    end
    if (cmd.fin) begin
      ov_r <= cmd.fin_use_est ? est_r : v_r;
      op_r <= p_r;
      of_r <= f_plus_ff;
      oc_r <= cmd.fin_conv;
    end
  end

  assign out_new_velocity = ov_r;
  assign out_new_position = op_r;
  assign out_new_force    = of_r;
  assign out_converged    = oc_r;

endmodule

>>> sv/lcis_ctrl.sv
// ----------------------------------------------------------------------------
// lcis_ctrl: integrator sequencer
// Walks each item through kick, drift and friction rounds by issuing
// datapath commands; owns the handshakes and the round counter.
// ----------------------------------------------------------------------------
module lcis_ctrl import lcis_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [MODE_W-1:0] in_mode,
  output logic              out_valid,
  input  logic              out_ready,
  input  logic              cfg_enable,
  input  logic [ITER_W-1:0] cfg_iter_limit,
  input  lcis_sts_t         sts,
  output lcis_cmd_t         cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PREP   = 4'd1;
  localparam logic [3:0] S_KMUL   = 4'd2;
  localparam logic [3:0] S_KMULW  = 4'd3;
  localparam logic [3:0] S_KDIVW  = 4'd4;
  localparam logic [3:0] S_NEXT   = 4'd5;
  localparam logic [3:0] S_FRICW  = 4'd6;
  localparam logic [3:0] S_FSUM   = 4'd7;
  localparam logic [3:0] S_DRIFTW = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;

  logic [3:0]        state_r, state_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [ITER_W-1:0] k_r, k_nxt;
  logic              conv_r, conv_nxt;
  logic              out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    mode_nxt  = mode_r;
    k_nxt     = k_r;
    conv_nxt  = conv_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          mode_nxt  = in_mode;
          k_nxt     = '0;
          conv_nxt  = 1'b0;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        if (!cfg_enable || !(mode_r == MODE_KICK_DRIFT || mode_r == MODE_FRICTION ||
                              mode_r == MODE_FINAL_KICK)) begin
          state_nxt = S_FIN;
        end else begin
          cmd.f_add_r = (mode_r == MODE_FRICTION);
          state_nxt   = S_KMUL;
        end
      end
      S_KMUL: begin
        cmd.mul_start = 1'b1;
        cmd.mul_a_sel = OPA_HALF;
        state_nxt     = S_KMULW;
      end
      S_KMULW: begin
        if (sts.mul_done) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_KDIVW;
        end
      end
      S_KDIVW: begin
        if (sts.div_done) begin
          cmd.est_load = 1'b1;
          state_nxt    = S_NEXT;
        end
      end
      S_NEXT: begin
        case (mode_r)
          MODE_KICK_DRIFT: begin
            cmd.mul_start = 1'b1;
            cmd.mul_a_sel = OPA_STEP;
            cmd.mul_b_est = 1'b1;
            state_nxt     = S_DRIFTW;
          end
          MODE_FRICTION: begin
            if (k_r != '0 && sts.tol_hit) begin
              conv_nxt  = 1'b1;
              state_nxt = S_FIN;
            end else if (k_r == cfg_iter_limit) begin
              state_nxt = S_FIN;
            end else begin
              cmd.round_start = 1'b1;
              cmd.mul_start   = 1'b1;
              cmd.mul_a_sel   = OPA_DRAG;
              cmd.mul_b_est   = 1'b1;
              k_nxt           = k_r + {{(ITER_W-1){1'b0}}, 1'b1};
              state_nxt       = S_FRICW;
            end
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_FRICW: begin
        if (sts.mul_done) begin
          cmd.ff_load = 1'b1;
          state_nxt   = S_FSUM;
        end
      end
      S_FSUM: begin
        cmd.x_fsum = 1'b1;
        state_nxt  = S_KMUL;
      end
      S_DRIFTW: begin
        if (sts.mul_done) begin
          cmd.p_load = 1'b1;
          state_nxt  = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.fin         = 1'b1;
          cmd.fin_use_est = cfg_enable &&
                            (mode_r == MODE_KICK_DRIFT || mode_r == MODE_FINAL_KICK);
          cmd.fin_conv    = conv_r;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cmd.fin) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_KICK_DRIFT;
      k_r         <= '0;
      conv_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      k_r         <= k_nxt;
      conv_r      <= conv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
